// File: design/line_tokenizer_core_defines.svh
// Assertion macros used by the tokenizer core RTL.
`ifndef LINE_TOKENIZER_CORE_DEFINES_SVH
`define LINE_TOKENIZER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LTOK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define LTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ltok_pkg.sv
`default_nettype none

package ltok_pkg;

  localparam int MAX_TOKEN_LEN = 32;
  localparam int MAX_TOKENS    = 16;

  localparam int CHAR_W = $clog2(MAX_TOKEN_LEN);
  localparam int TOK_W  = $clog2(MAX_TOKENS + 1);

  localparam logic [CHAR_W-1:0] CHAR_LIMIT = CHAR_W'(MAX_TOKEN_LEN - 1);
  localparam logic [TOK_W-1:0]  TOK_LIMIT  = TOK_W'(MAX_TOKENS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_FIRST = 8'h21;
  localparam logic [7:0] CH_LAST  = 8'h7E;

  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_TOKEN   = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;
  localparam logic [1:0] MODE_SKIP    = 2'd3;

  localparam logic [2:0] EV_CHAR     = 3'd0;
  localparam logic [2:0] EV_LINE     = 3'd1;
  localparam logic [2:0] EV_END      = 3'd2;
  localparam logic [2:0] EV_TOO_LONG = 3'd3;
  localparam logic [2:0] EV_TOO_MANY = 3'd4;
  localparam logic [2:0] EV_BAD      = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TOK_W-1:0]  tokens;
    logic [CHAR_W-1:0] chars;
    logic [15:0]       line;
  } ltok_state_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  char_value;
    logic [3:0]  token_index;
    logic [4:0]  char_index;
    logic [4:0]  token_count;
    logic [15:0] line_num;
  } ltok_result_t;

endpackage

`default_nettype wire

// File: design/ltok_if.sv
`default_nettype none

interface ltok_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ltok_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  char_value;
  logic [3:0]  token_index;
  logic [4:0]  char_index;
  logic [4:0]  token_count;
  logic [15:0] line_num;

  modport source (output valid, output event_kind, output char_value, output token_index,
                  output char_index, output token_count, output line_num, input ready);
  modport sink   (input valid, input event_kind, input char_value, input token_index,
                  input char_index, input token_count, input line_num, output ready);
endinterface

`default_nettype wire

// File: design/ltok_step.sv
`default_nettype none

module ltok_step (
  input  logic [7:0]            byte_i,
  input  ltok_pkg::ltok_state_t state_i,
  output ltok_pkg::ltok_state_t state_o,
  output logic                  emit_o,
  output ltok_pkg::ltok_result_t result_o
);
  import ltok_pkg::*;

  logic              is_blank;
  logic              is_graph;
  logic              surplus;
  logic [15:0]       line_inc;
  ltok_state_t       eff;
  logic [CHAR_W-1:0] cis;

  assign is_blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_VT) ||
                    (byte_i == CH_FF) || (byte_i == CH_CR);
  assign is_graph = (byte_i >= CH_FIRST) && (byte_i <= CH_LAST);
  assign surplus  = state_i.tokens >= TOK_LIMIT;
  assign line_inc = state_i.line + 16'd1;

  // A token that ends on a byte outside 0x21..0x7E (below the token limit) is counted
  // before the byte is looked at again as if between tokens.
  always_comb begin
    eff = state_i;
    if (state_i.mode == MODE_TOKEN && !is_graph && !surplus) begin
      eff.mode   = MODE_BETWEEN;
      eff.tokens = state_i.tokens + TOK_W'(1);
      eff.chars  = '0;
    end
  end

  assign cis = (state_i.mode == MODE_TOKEN) ? state_i.chars : '0;

  always_comb begin
    state_o  = eff;
    emit_o   = 1'b0;
    result_o = '0;

    if (state_i.mode == MODE_TOKEN && !is_graph && surplus) begin
      emit_o               = 1'b1;
      result_o.event_kind  = EV_TOO_MANY;
      result_o.token_count = 5'(state_i.tokens);
      result_o.line_num    = line_inc;
      state_o.chars        = '0;
      state_o.line         = line_inc;
      if (byte_i == CH_NUL) begin
        state_o = '0;
      end else if (byte_i == CH_LF) begin
        state_o.tokens = '0;
        state_o.mode   = MODE_BETWEEN;
      end else begin
        state_o.mode = MODE_SKIP;
      end
    end else if (is_graph && (state_i.mode == MODE_TOKEN ||
                 (state_i.mode == MODE_BETWEEN && byte_i != CH_SEMI))) begin
      if (cis >= CHAR_LIMIT) begin
        emit_o               = 1'b1;
        result_o.event_kind  = EV_TOO_LONG;
        result_o.token_count = 5'(state_i.tokens);
        result_o.line_num    = line_inc;
        state_o.chars        = '0;
        state_o.mode         = MODE_SKIP;
        state_o.line         = line_inc;
      end else begin
        state_o.mode  = MODE_TOKEN;
        state_o.chars = cis + CHAR_W'(1);
        if (!surplus) begin
          emit_o               = 1'b1;
          result_o.event_kind  = EV_CHAR;
          result_o.char_value  = byte_i;
          result_o.token_index = 4'(state_i.tokens);
          result_o.char_index  = 5'(cis);
        end
      end
    end else if (byte_i == CH_NUL) begin
      emit_o               = 1'b1;
      result_o.event_kind  = EV_END;
      result_o.token_count = 5'(eff.tokens);
      result_o.line_num    = line_inc;
      state_o              = '0;
    end else begin
      case (eff.mode)
        MODE_BETWEEN: begin
          if (byte_i == CH_LF) begin
            emit_o               = 1'b1;
            result_o.event_kind  = EV_LINE;
            result_o.token_count = 5'(eff.tokens);
            result_o.line_num    = line_inc;
            state_o.line         = line_inc;
            state_o.tokens       = '0;
          end else if (byte_i == CH_SEMI) begin
            state_o.mode = MODE_COMMENT;
          end else if (!is_blank) begin
            emit_o               = 1'b1;
            result_o.event_kind  = EV_BAD;
            result_o.token_count = 5'(eff.tokens);
            result_o.line_num    = line_inc;
            state_o.line         = line_inc;
            state_o.mode         = MODE_SKIP;
          end
        end
        MODE_COMMENT: begin
          if (byte_i == CH_LF) begin
            emit_o               = 1'b1;
            result_o.event_kind  = EV_LINE;
            result_o.token_count = 5'(eff.tokens);
            result_o.line_num    = line_inc;
            state_o.line         = line_inc;
            state_o.tokens       = '0;
            state_o.mode         = MODE_BETWEEN;
          end
        end
        MODE_SKIP: begin
          if (byte_i == CH_LF) begin
            state_o.tokens = '0;
            state_o.chars  = '0;
            state_o.mode   = MODE_BETWEEN;
          end
        end
        default: begin
          state_o = eff;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/line_tokenizer_core.sv
// Channel  Dir  Payload                                              Role
// text_i   in   text_byte[7:0]                                       text, one byte per word
// event_o  out  event_kind, char_value, token_index, char_index,     token characters,
//               token_count, line_num                                line and error events
//
// Throughput is one byte per cycle while no pending event is stalled on event_o.
// A byte is held in the input register until the result register can take its event,
// then decoded, and its event, if any, is registered in the result register for event_o.
// A stalled event_o holds the result register, and the input register then
// absorbs one more byte before text_i.ready drops.
// Reset (rst_ni low, asynchronous) empties both registers and clears the scan state.
`default_nettype none

module line_tokenizer_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ltok_byte_if.sink    text_i,
  ltok_event_if.source event_o
);
  import ltok_pkg::*;

  `include "line_tokenizer_core_defines.svh"

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         out_valid_q, out_valid_d;
  ltok_result_t out_q;
  ltok_state_t  state_q, state_d;
  ltok_result_t step_result;
  logic         step_emit;
  logic         advance;
  logic         in_take;
  logic         counters_ok;
  logic         step_end;
  logic         quiet_step;

  assign advance      = in_valid_q && (!out_valid_q || event_o.ready);
  assign text_i.ready = !in_valid_q || advance;
  assign in_take      = text_i.valid && text_i.ready;

  ltok_step u_step (
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .emit_o   (step_emit),
    .result_o (step_result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && step_emit) begin
      out_valid_d = 1'b1;
    end else if (event_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= text_i.text_byte;
    end
    if (advance && step_emit) begin
      out_q <= step_result;
    end
  end

  assign event_o.valid       = out_valid_q;
  assign event_o.event_kind  = out_q.event_kind;
  assign event_o.char_value  = out_q.char_value;
  assign event_o.token_index = out_q.token_index;
  assign event_o.char_index  = out_q.char_index;
  assign event_o.token_count = out_q.token_count;
  assign event_o.line_num    = out_q.line_num;

  assign counters_ok = (state_q.chars <= CHAR_LIMIT) && (state_q.tokens <= TOK_LIMIT);
  assign step_end    = advance && step_emit && (step_result.event_kind == EV_END);
  assign quiet_step  = advance && !step_emit && !out_valid_q;

  `LTOK_ASSERT_ALWAYS(a_ready_only_when_full, text_i.ready || in_valid_q, "ready low while empty")
  `LTOK_ASSERT_ALWAYS(a_state_bounds, counters_ok, "scan counters out of range")
  `LTOK_ASSERT_NEXT(a_end_clears, step_end, (state_q == '0) && out_valid_q, "state not cleared")
  `LTOK_ASSERT_NEXT(a_no_result_no_load, quiet_step, !out_valid_q, "event for a silent byte")

endmodule

`default_nettype wire
